FILE: hw/rtl/c2g_pkg.sv
// c2g_pkg: shared types, constants and the arctangent table of the
// cartesian-to-geodetic core. No dependencies.
`default_nettype none
package c2g_pkg;

  // angle width: radians scaled by 2^30, signed, with headroom for the accumulator
  localparam int ANG_W = 34;
  typedef logic signed [ANG_W-1:0] ang_t;

  localparam int CORDIC_STEPS = 31;
  localparam logic signed [63:0] KINV_Q30    = 64'sd652032874;
  localparam logic signed [63:0] ONE_Q30     = 64'sd1073741824;
  localparam ang_t               HALF_PI_Q30 = 34'sd1686629713;

  // request to the cordic unit
  typedef struct packed {
    logic start;
    logic vec;     // 1 vectoring, 0 rotation
  } cordic_req_t;

  // request to the multiplier: (a * b + round) >> sh
  typedef struct packed {
    logic       start;
    logic       rnd;
    logic [5:0] sh;
  } mul_req_t;

  // arctangent of 2^-i, radians scaled by 2^30
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/c2g_if.sv
// c2g_in_if / c2g_out_if: valid-ready channels of the cartesian-to-geodetic core.
// Depends on nothing.
`default_nettype none
interface c2g_in_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] pos_x;
  logic signed [39:0] pos_y;
  logic signed [39:0] pos_z;
  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface c2g_out_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] latitude;
  logic        [40:0] longitude;
  logic signed [39:0] height;
  logic        [1:0]  status;
  modport source (output valid, output latitude, output longitude, output height,
                  output status, input ready);
  modport sink   (input valid, input latitude, input longitude, input height,
                  input status, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/c2g_cordic.sv
// c2g_cordic: iterative cordic, one micro-rotation per cycle, rotation and
// vectoring modes. Depends on c2g_pkg.
`default_nettype none
module c2g_cordic
  import c2g_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cordic_req_t        req,
  input  wire logic signed [63:0] x_in,
  input  wire logic signed [63:0] y_in,
  input  wire ang_t               ang_in,
  output logic                    done,
  output logic signed [63:0]      x_out,
  output logic signed [63:0]      y_out,
  output ang_t                    ang_out
);

  logic signed [63:0] x_r, y_r;
  ang_t               ang_r;
  logic [4:0]         step_r;
  logic               busy_r, done_r, vec_r;

  logic signed [63:0] dx, dy;
  ang_t               da;
  logic               sub_dir;

  // one micro-rotation
  always_comb begin
    dx      = y_r >>> step_r;
    dy      = x_r >>> step_r;
    da      = ang_t'(atan_entry(step_r));
    sub_dir = vec_r ? y_r[63] : ~ang_r[ANG_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        vec_r  <= req.vec;
        if (!req.vec) begin
          x_r   <= KINV_Q30;
          y_r   <= '0;
          ang_r <= ang_in;
        end else if (x_in[63] && !y_in[63]) begin
          // left half plane: pre-rotate by a quarter turn
          x_r   <= y_in;
          y_r   <= -x_in;
          ang_r <= HALF_PI_Q30;
        end else if (x_in[63]) begin
          x_r   <= -y_in;
          y_r   <= x_in;
          ang_r <= -HALF_PI_Q30;
        end else begin
          x_r   <= x_in;
          y_r   <= y_in;
          ang_r <= '0;
        end
      end else if (busy_r) begin
        if (sub_dir) begin
          x_r   <= x_r - dx;
          y_r   <= y_r + dy;
          ang_r <= ang_r - da;
        end else begin
          x_r   <= x_r + dx;
          y_r   <= y_r - dy;
          ang_r <= ang_r + da;
        end
        if (step_r == 5'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 5'd1;
      end
    end
  end

  // rotation results are clamped to the unit range
  always_comb begin
    x_out = x_r;
    y_out = y_r;
    if (!vec_r) begin
      if (x_r < 0)            x_out = '0;
      else if (x_r > ONE_Q30) x_out = ONE_Q30;
      if (y_r > ONE_Q30)       y_out = ONE_Q30;
      else if (y_r < -ONE_Q30) y_out = -ONE_Q30;
    end
  end

  assign ang_out = ang_r;
  assign done    = done_r;

endmodule
`default_nettype wire

FILE: hw/rtl/c2g_mul.sv
// c2g_mul: 64 x 64 multiplier with rounding shift, built from one 32 x 32
// multiplier used once per partial product. Depends on c2g_pkg.
`default_nettype none
module c2g_mul
  import c2g_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire mul_req_t    req,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      p
);

  logic [63:0]  a_r, b_r;
  logic [5:0]   sh_r;
  logic [127:0] acc_r;
  logic [1:0]   cnt_r;
  logic         busy_r, done_r;

  logic [31:0]  pa, pb;
  logic [63:0]  prod;
  logic [1:0]   pos;
  logic [127:0] shifted;

  // partial product of the current half words
  always_comb begin
    pa      = cnt_r[0] ? a_r[63:32] : a_r[31:0];
    pb      = cnt_r[1] ? b_r[63:32] : b_r[31:0];
    prod    = pa * pb;
    pos     = 2'(cnt_r[0]) + 2'(cnt_r[1]);
    shifted = acc_r >> sh_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        a_r    <= a;
        b_r    <= b;
        sh_r   <= req.sh;
        acc_r  <= req.rnd ? (128'd1 << (req.sh - 6'd1)) : '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_r + ({64'd0, prod} << {pos, 5'd0});
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign p    = shifted[63:0];
  assign done = done_r;

endmodule
`default_nettype wire

FILE: hw/rtl/c2g_sqrt.sv
// c2g_sqrt: floor square root, two radicand bits per cycle.
// Depends on nothing.
`default_nettype none
module c2g_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] v,
  output logic             done,
  output logic [30:0]      root
);

  logic [63:0] v_r, r_r, bit_r, sum;
  logic        busy_r, done_r;

  assign sum = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r    <= v;
        r_r    <= '0;
        bit_r  <= 64'h4000_0000_0000_0000;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (v_r >= sum) begin
          v_r <= v_r - sum;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign root = r_r[30:0];
  assign done = done_r;

endmodule
`default_nettype wire

FILE: hw/rtl/c2g_div.sv
// c2g_div: radius of curvature a * 2^30 / d by restoring division, one
// quotient bit per cycle, saturating at 2^44. Depends on nothing.
`default_nettype none
module c2g_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [38:0] dividend,
  input  wire logic [30:0] divisor,
  output logic             done,
  output logic [44:0]      quot
);

  localparam int QW = 69;

  logic [QW-1:0] q_r;
  logic [30:0]   rem_r, d_r;
  logic [31:0]   trial;
  logic [6:0]    cnt_r;
  logic          busy_r, done_r, fits;

  always_comb begin
    trial = {rem_r, q_r[QW-1]};
    fits  = trial >= {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= {dividend, 30'd0};
        d_r    <= divisor;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? 31'(trial - {1'b0, d_r}) : trial[30:0];
        q_r   <= {q_r[QW-2:0], fits};
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // saturate at 2^44
  assign quot = (q_r >= (69'd1 << 44)) ? (45'd1 << 44) : q_r[44:0];
  assign done = done_r;

endmodule
`default_nettype wire

FILE: hw/rtl/cartesian_to_geodetic_core.sv
// cartesian_to_geodetic_core: top level, sequencer and configuration registers.
// Depends on c2g_pkg, c2g_if, c2g_cordic, c2g_mul, c2g_sqrt, c2g_div.
//
// Converts a body-fixed position (2^-16 km units) into latitude and east
// longitude (degrees scaled by 2^32) and height above the ellipsoid. One
// position is handled at a time: a sequencer drives a shared cordic, a
// multiplier, a square root and a divider. Geodetic latitude takes k
// geodetic refinement steps, where k is at most MAX_ITER; each step is set
// mostly by the divider and the two cordic passes. Geocentric or reduced
// latitude adds a multiply and one more cordic pass. A position on the polar
// axis goes from idle straight to the output step. The input is ready
// only while the sequencer is idle; the finished result sits in an output
// register, so a new position may be taken while the previous result waits.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata; the user must
// do so only while the core is idle, which the core itself does not enforce.
`default_nettype none
module cartesian_to_geodetic_core
  import c2g_pkg::*;
#(
  parameter int MAX_ITER = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  c2g_in_if.sink           in_ch,
  c2g_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [38:0] cfg_wdata
);

  localparam int NW = $clog2(MAX_ITER + 1);

  localparam logic [1:0] CFG_RADIUS = 2'd0;
  localparam logic [1:0] CFG_FLAT   = 2'd1;
  localparam logic [1:0] CFG_KIND   = 2'd2;

  localparam logic [1:0] KIND_GEOCENTRIC = 2'd1;
  localparam logic [1:0] KIND_REDUCED    = 2'd2;

  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_CAP       = 2'd1;
  localparam logic [1:0] ST_POLAR     = 2'd2;

  localparam logic [ANG_W:0]     TOL_Q30    = (ANG_W+1)'(10);
  localparam logic [63:0]        DEG_Q22    = 64'd961263669;
  localparam logic [39:0]        LAT_LIMIT  = 40'd386547056640;
  localparam logic [40:0]        FULL_TURN  = 41'd1546188226560;
  localparam logic signed [63:0] HEIGHT_MAX = 64'sd549755813887;
  localparam logic signed [63:0] HEIGHT_MIN = -64'sd549755813888;
  localparam logic [63:0]        TWO_P60    = 64'h1000_0000_0000_0000;

  typedef enum logic [4:0] {
    S_IDLE, S_E2, S_LON, S_P16, S_SEED, S_CHECK, S_ROT, S_SQR, S_TERM, S_ROOT,
    S_CURV, S_NE2, S_NS, S_VEC, S_HZ, S_PC, S_AD, S_YS, S_LVEC, S_LAT,
    S_LON_DEG, S_OUT
  } state_t;

  // configuration registers
  logic [38:0] radius_r;
  logic [31:0] flat_r;
  logic [1:0]  kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 39'd417997541;
      flat_r   <= 32'd14400212;
      kind_r   <= 2'd0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_RADIUS: radius_r <= cfg_wdata;
        CFG_FLAT:   flat_r   <= cfg_wdata[31:0];
        CFG_KIND:   kind_r   <= cfg_wdata[1:0];
        default:    ;
      endcase
    end
  end

  // working registers
  state_t             state_r;
  logic               issued_r, fin_r;
  logic signed [39:0] px_r, py_r, pz_r;
  logic [61:0]        e2_r;
  logic [63:0]        p16_r, tmp_r;
  ang_t               lon_ang_r, cur_r, old_r, ang_r;
  logic [NW-1:0]      n_r;
  logic signed [31:0] s_r;
  logic [30:0]        c_r, d_r;
  logic [44:0]        nc_r;
  logic signed [63:0] h_r;
  logic [1:0]         st_r;
  logic signed [39:0] lat_q, hgt_q;
  logic [40:0]        lon_q;
  logic               out_valid_r;
  logic signed [39:0] out_lat_r, out_hgt_r;
  logic [40:0]        out_lon_r;
  logic [1:0]         out_st_r;

  // shared units
  cordic_req_t        cor_req;
  logic signed [63:0] cor_xi, cor_yi, cor_xo, cor_yo;
  ang_t               cor_ai, cor_ao;
  logic               cor_done;
  mul_req_t           mul_req;
  logic [63:0]        mul_a, mul_b, mul_p;
  logic               mul_done;
  logic               sq_start, sq_done, dv_start, dv_done;
  logic [30:0]        sq_root;
  logic [44:0]        dv_quot;

  c2g_cordic u_cordic (
    .clk, .rst_n, .req(cor_req), .x_in(cor_xi), .y_in(cor_yi), .ang_in(cor_ai),
    .done(cor_done), .x_out(cor_xo), .y_out(cor_yo), .ang_out(cor_ao)
  );

  c2g_mul u_mul (
    .clk, .rst_n, .req(mul_req), .a(mul_a), .b(mul_b), .done(mul_done), .p(mul_p)
  );

  c2g_sqrt u_sqrt (
    .clk, .rst_n, .start(sq_start), .v(tmp_r), .done(sq_done), .root(sq_root)
  );

  c2g_div u_div (
    .clk, .rst_n, .start(dv_start), .dividend(radius_r), .divisor(d_r),
    .done(dv_done), .quot(dv_quot)
  );

  // derived operands
  logic signed [63:0] z16;
  logic [31:0]        s_mag;
  logic [39:0]        z_mag;
  logic [ANG_W:0]     diff, diff_mag;
  logic               conv, geodetic, in_take, out_free;
  logic [ANG_W-1:0]   ang_mag, lon_mag;
  logic signed [63:0] h_sum, ys16;
  logic [40:0]        lm_c, lon_raw;
  logic               mul_state, cor_state, unit_done, mul_go, cor_go;

  always_comb begin
    z16      = {{8{pz_r[39]}}, pz_r, 16'd0};
    s_mag    = s_r[31] ? 32'(-s_r) : 32'(s_r);
    z_mag    = pz_r[39] ? 40'(-pz_r) : 40'(pz_r);
    diff     = {cur_r[ANG_W-1], cur_r} - {old_r[ANG_W-1], old_r};
    diff_mag = diff[ANG_W] ? (ANG_W+1)'(-diff) : diff;
    conv     = diff_mag <= TOL_Q30;
    geodetic = (kind_r != KIND_GEOCENTRIC) && (kind_r != KIND_REDUCED);
    ang_mag  = ang_r[ANG_W-1] ? ANG_W'(-ang_r) : ANG_W'(ang_r);
    lon_mag  = lon_ang_r[ANG_W-1] ? ANG_W'(-lon_ang_r) : ANG_W'(lon_ang_r);
    h_sum    = h_r - $signed(mul_p);
    ys16     = {tmp_r[47:0], 16'd0};
    lm_c     = (mul_p > 64'(FULL_TURN)) ? FULL_TURN : mul_p[40:0];
    lon_raw  = lon_ang_r[ANG_W-1] ? FULL_TURN - lm_c : lm_c;
    in_take  = in_ch.valid && (state_r == S_IDLE);
    out_free = !out_valid_r || out_ch.ready;
  end

  // operand selection for the multiplier
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    mul_req.start = mul_go;
    mul_req.sh = 6'd30;
    mul_req.rnd = 1'b1;
    unique case (state_r)
      S_E2: begin
        mul_a = {32'd0, flat_r};
        mul_b = {30'd0, 34'h2_0000_0000 - {2'b00, flat_r}};
        mul_req.sh = 6'd2;
        mul_req.rnd = 1'b0;
      end
      S_P16: begin
        mul_a = tmp_r;
        mul_b = 64'(KINV_Q30);
        mul_req.sh = 6'd34;
      end
      S_SQR: begin
        mul_a = {32'd0, s_mag};
        mul_b = {32'd0, s_mag};
        mul_req.sh = 6'd0;
        mul_req.rnd = 1'b0;
      end
      S_TERM: begin
        mul_a = {2'b00, e2_r};
        mul_b = tmp_r;
        mul_req.sh = 6'd62;
      end
      S_NE2: begin
        mul_a = {19'd0, nc_r};
        mul_b = {2'b00, e2_r};
        mul_req.sh = 6'd46;
      end
      S_NS: begin
        mul_a = tmp_r;
        mul_b = {32'd0, s_mag};
      end
      S_HZ: begin
        mul_a = {24'd0, z_mag};
        mul_b = {32'd0, s_mag};
      end
      S_PC: begin
        mul_a = p16_r;
        mul_b = {33'd0, c_r};
        mul_req.sh = 6'd46;
      end
      S_AD: begin
        mul_a = {25'd0, radius_r};
        mul_b = {33'd0, d_r};
      end
      S_YS: begin
        mul_a = {32'd0, s_mag};
        if (kind_r == KIND_GEOCENTRIC) begin
          mul_b = 64'h4000_0000_0000_0000 - {2'b00, e2_r};
          mul_req.sh = 6'd62;
        end else begin
          mul_b = 64'h1_0000_0000 - {32'd0, flat_r};
          mul_req.sh = 6'd32;
        end
      end
      S_LAT: begin
        mul_a = 64'(ang_mag);
        mul_b = DEG_Q22;
        mul_req.sh = 6'd22;
      end
      S_LON_DEG: begin
        mul_a = 64'(lon_mag);
        mul_b = DEG_Q22;
        mul_req.sh = 6'd22;
      end
      default: ;
    endcase
  end

  // operand selection for the cordic
  always_comb begin
    cor_xi      = '0;
    cor_yi      = '0;
    cor_ai      = cur_r;
    cor_req.start = cor_go;
    cor_req.vec = 1'b1;
    unique case (state_r)
      S_LON: begin
        cor_xi = {{4{px_r[39]}}, px_r, 20'd0};
        cor_yi = {{4{py_r[39]}}, py_r, 20'd0};
      end
      S_SEED: begin
        cor_xi = $signed(p16_r);
        cor_yi = z16;
      end
      S_ROT: cor_req.vec = 1'b0;
      S_VEC: begin
        cor_xi = $signed(p16_r);
        cor_yi = s_r[31] ? z16 - $signed(tmp_r) : z16 + $signed(tmp_r);
      end
      S_LVEC: begin
        cor_xi = {17'd0, c_r, 16'd0};
        cor_yi = s_r[31] ? -ys16 : ys16;
      end
      default: ;
    endcase
  end

  // unit starts and completion for the current step
  always_comb begin
    mul_state = (state_r == S_E2) || (state_r == S_P16) || (state_r == S_SQR) ||
                (state_r == S_TERM) || (state_r == S_NE2) || (state_r == S_NS) ||
                (state_r == S_HZ) || (state_r == S_PC) || (state_r == S_AD) ||
                (state_r == S_LAT) || (state_r == S_LON_DEG) ||
                ((state_r == S_YS) && !geodetic);
    cor_state = (state_r == S_LON) || (state_r == S_SEED) || (state_r == S_ROT) ||
                (state_r == S_VEC) || (state_r == S_LVEC);
    mul_go    = mul_state && !issued_r;
    cor_go    = cor_state && !issued_r;
    sq_start  = (state_r == S_ROOT) && !issued_r;
    dv_start  = (state_r == S_CURV) && !issued_r;
    unit_done = (mul_state && mul_done) || (cor_state && cor_done) ||
                ((state_r == S_ROOT) && sq_done) || ((state_r == S_CURV) && dv_done);
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != S_OUT)) out_valid_r <= 1'b0;
      issued_r <= unit_done ? 1'b0
                : (issued_r | mul_go | cor_go | sq_start | dv_start);
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            px_r  <= in_ch.pos_x;
            py_r  <= in_ch.pos_y;
            pz_r  <= in_ch.pos_z;
            fin_r <= 1'b0;
            if (in_ch.pos_x == '0 && in_ch.pos_y == '0) begin
              // polar axis: fixed answer, height saturated
              lat_q   <= in_ch.pos_z > 0 ? $signed(LAT_LIMIT)
                       : (in_ch.pos_z < 0 ? -$signed(LAT_LIMIT) : 40'sd0);
              lon_q   <= '0;
              hgt_q   <= 40'(HEIGHT_MAX);
              st_r    <= ST_POLAR;
              state_r <= S_OUT;
            end else begin
              state_r <= S_E2;
            end
          end
        end
        S_E2: if (unit_done) begin
          e2_r    <= mul_p[61:0];
          state_r <= S_LON;
        end
        S_LON: if (unit_done) begin
          lon_ang_r <= cor_ao;
          tmp_r     <= cor_xo[63] ? '0 : cor_xo;
          state_r   <= S_P16;
        end
        S_P16: if (unit_done) begin
          p16_r   <= mul_p;
          state_r <= S_SEED;
        end
        S_SEED: if (unit_done) begin
          cur_r   <= cor_ao;
          old_r   <= '0;
          n_r     <= '0;
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (!conv && n_r < NW'(MAX_ITER)) begin
            old_r <= cur_r;
          end else begin
            st_r  <= conv ? ST_CONVERGED : ST_CAP;
            fin_r <= 1'b1;
          end
          state_r <= S_ROT;
        end
        S_ROT: if (unit_done) begin
          c_r     <= cor_xo[30:0];
          s_r     <= cor_yo[31:0];
          state_r <= S_SQR;
        end
        S_SQR: if (unit_done) begin
          tmp_r   <= mul_p;
          state_r <= S_TERM;
        end
        S_TERM: if (unit_done) begin
          // 1 - e2 sin^2, floored at one unit
          tmp_r   <= (mul_p >= TWO_P60) ? 64'd1 : TWO_P60 - mul_p;
          state_r <= S_ROOT;
        end
        S_ROOT: if (unit_done) begin
          d_r     <= sq_root;
          state_r <= fin_r ? S_HZ : S_CURV;
        end
        S_CURV: if (unit_done) begin
          nc_r    <= dv_quot;
          state_r <= S_NE2;
        end
        S_NE2: if (unit_done) begin
          tmp_r   <= mul_p;
          state_r <= S_NS;
        end
        S_NS: if (unit_done) begin
          tmp_r   <= mul_p;
          state_r <= S_VEC;
        end
        S_VEC: if (unit_done) begin
          cur_r   <= cor_ao;
          n_r     <= n_r + NW'(1);
          state_r <= S_CHECK;
        end
        S_HZ: if (unit_done) begin
          h_r     <= (pz_r[39] != s_r[31]) ? -$signed(mul_p) : $signed(mul_p);
          state_r <= S_PC;
        end
        S_PC: if (unit_done) begin
          h_r     <= h_r + $signed(mul_p);
          state_r <= S_AD;
        end
        S_AD: if (unit_done) begin
          if (h_sum > HEIGHT_MAX)      hgt_q <= 40'(HEIGHT_MAX);
          else if (h_sum < HEIGHT_MIN) hgt_q <= 40'(HEIGHT_MIN);
          else                         hgt_q <= h_sum[39:0];
          state_r <= S_YS;
        end
        S_YS: begin
          if (geodetic) begin
            ang_r   <= cur_r;
            state_r <= S_LAT;
          end else if (unit_done) begin
            tmp_r   <= mul_p;
            state_r <= S_LVEC;
          end
        end
        S_LVEC: if (unit_done) begin
          ang_r   <= cor_ao;
          state_r <= S_LAT;
        end
        S_LAT: if (unit_done) begin
          if (mul_p > 64'(LAT_LIMIT))
            lat_q <= ang_r[ANG_W-1] ? -$signed(LAT_LIMIT) : $signed(LAT_LIMIT);
          else
            lat_q <= ang_r[ANG_W-1] ? -$signed(mul_p[39:0]) : $signed(mul_p[39:0]);
          state_r <= S_LON_DEG;
        end
        S_LON_DEG: if (unit_done) begin
          lon_q   <= (lon_raw >= FULL_TURN) ? lon_raw - FULL_TURN : lon_raw;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_lat_r   <= lat_q;
            out_lon_r   <= lon_q;
            out_hgt_r   <= hgt_q;
            out_st_r    <= st_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.latitude  = out_lat_r;
  assign out_ch.longitude = out_lon_r;
  assign out_ch.height    = out_hgt_r;
  assign out_ch.status    = out_st_r;

endmodule
`default_nettype wire
